// ----- src/pps_pkg.sv -----
// Shared constants, codes and types of the preemptive priority scheduler.
package pps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 16;
    localparam int BURST_W   = 16;
    localparam int PRI_W     = 8;
    localparam int PID_W     = 4;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic             load;
        logic             rd_runner;
        logic             scan_first;
        logic             scan_eval;
        logic             update;
        logic [CNT_W-1:0] scan_cnt;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
    } status_t;

endpackage

// ----- src/pps_ctrl.sv -----
// Controller state machine that sequences loads, the entry scan and the tick update.
module pps_ctrl
    import pps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    op,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start && (op == OP_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == status.entry_count)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy           = 1'b1;
        cmd.load       = 1'b0;
        cmd.rd_runner  = 1'b0;
        cmd.scan_first = 1'b0;
        cmd.scan_eval  = 1'b0;
        cmd.update     = 1'b0;
        cmd.scan_cnt   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy          = 1'b0;
                cmd.rd_runner = 1'b1;
                cmd.load      = start && (op == OP_LOAD);
            end
            ST_SCAN:
            begin
                cmd.scan_first = (cnt_reg == '0);
                cmd.scan_eval  = (cnt_reg != '0);
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // The scan never walks past the loaded entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= status.entry_count))
        else $error("scan counter ran past the entry count");

    // An accepted tick always starts a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && start && (op == OP_TICK)) |=> (state_reg == ST_SCAN))
        else $error("accepted tick did not start a scan");

    // The update state is followed directly by idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (state_reg == ST_IDLE))
        else $error("update did not return to idle");

endmodule

// ----- src/pps_datapath.sv -----
// Datapath with the process stores, the best-candidate comparator and the result registers.
module pps_datapath
    import pps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [TIME_W-1:0]  arrival,
    input  logic [BURST_W-1:0] burst,
    input  logic [PRI_W-1:0]   priority_req,
    output status_t            status,
    output logic               result_valid,
    output logic [TIME_W-1:0]  tick_time,
    output logic               idle,
    output logic [PID_W-1:0]   process_id,
    output logic               finished
);

    logic [TIME_W-1:0]  arr_mem [MAX_PROCS];
    logic [BURST_W-1:0] rem_mem [MAX_PROCS];
    logic [PRI_W-1:0]   pri_mem [MAX_PROCS];

    logic [TIME_W-1:0]  rd_arr_reg;
    logic [BURST_W-1:0] rd_rem_reg;
    logic [PRI_W-1:0]   rd_pri_reg;

    logic [MAX_PROCS-1:0] done_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [IDX_W-1:0]     runner_idx_reg;
    logic                 runner_valid_reg;

    logic                 have_reg;
    logic                 fresh_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [TIME_W-1:0]    best_arr_reg;
    logic [BURST_W-1:0]   best_rem_reg;
    logic [PRI_W-1:0]     best_pri_reg;

    logic                 res_valid_reg;
    logic [TIME_W-1:0]    res_time_reg;
    logic                 res_idle_reg;
    logic [PID_W-1:0]     res_pid_reg;
    logic                 res_fin_reg;

    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     cand_idx;
    logic [IDX_W-1:0]     load_idx;
    logic                 load_ok;
    logic                 cand_elig;
    logic                 cand_beats;
    logic                 take;
    logic [BURST_W-1:0]   new_rem;

    assign load_idx = count_reg[IDX_W-1:0];
    assign load_ok  = cmd.load && (count_reg < CNT_W'(MAX_PROCS));
    assign rd_addr  = cmd.rd_runner ? runner_idx_reg : cmd.scan_cnt[IDX_W-1:0];
    assign cand_idx = cmd.scan_first ? runner_idx_reg
                                     : IDX_W'(cmd.scan_cnt - 1'b1);
    assign new_rem  = best_rem_reg - 1'b1;

    always_comb
    begin
        cand_elig = !done_reg[cand_idx] && (rd_arr_reg <= time_reg);
        if (cmd.scan_first)
        begin
            cand_elig = cand_elig && runner_valid_reg
                        && (CNT_W'(runner_idx_reg) < count_reg);
        end
    end

    always_comb
    begin
        if (rd_pri_reg != best_pri_reg)
        begin
            cand_beats = rd_pri_reg < best_pri_reg;
        end
        else if (fresh_reg)
        begin
            cand_beats = rd_arr_reg < best_arr_reg;
        end
        else
        begin
            cand_beats = (rd_arr_reg == best_arr_reg) && (rd_rem_reg < best_rem_reg);
        end
    end

    assign take = cmd.scan_first ? cand_elig
                : (cmd.scan_eval && cand_elig
                   && (!have_reg || ((cand_idx != best_idx_reg) && cand_beats)));

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            arr_mem[load_idx] <= arrival;
            rem_mem[load_idx] <= burst;
            pri_mem[load_idx] <= priority_req;
        end
        else if (cmd.update && have_reg)
        begin
            rem_mem[best_idx_reg] <= new_rem;
        end
        rd_arr_reg <= arr_mem[rd_addr];
        rd_rem_reg <= rem_mem[rd_addr];
        rd_pri_reg <= pri_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cand_idx;
            best_arr_reg <= rd_arr_reg;
            best_rem_reg <= rd_rem_reg;
            best_pri_reg <= rd_pri_reg;
        end
        if (cmd.update)
        begin
            res_time_reg <= time_reg;
            res_idle_reg <= !have_reg;
            res_pid_reg  <= have_reg ? PID_W'(best_idx_reg) : '0;
            res_fin_reg  <= have_reg && (new_rem == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= '0;
            count_reg        <= '0;
            time_reg         <= '0;
            runner_idx_reg   <= '0;
            runner_valid_reg <= 1'b0;
            have_reg         <= 1'b0;
            fresh_reg        <= 1'b1;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.update;
            if (load_ok)
            begin
                done_reg[load_idx] <= (burst == '0);
                count_reg          <= count_reg + 1'b1;
            end
            if (cmd.scan_first)
            begin
                have_reg  <= cand_elig;
                fresh_reg <= !cand_elig;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.update)
            begin
                time_reg <= time_reg + 1'b1;
                if (have_reg && (new_rem != '0))
                begin
                    runner_valid_reg <= 1'b1;
                    runner_idx_reg   <= best_idx_reg;
                end
                else
                begin
                    runner_valid_reg <= 1'b0;
                end
                if (have_reg && (new_rem == '0))
                begin
                    done_reg[best_idx_reg] <= 1'b1;
                end
            end
        end
    end

    assign status.entry_count = count_reg;
    assign result_valid       = res_valid_reg;
    assign tick_time          = res_time_reg;
    assign idle               = res_idle_reg;
    assign process_id         = res_pid_reg;
    assign finished           = res_fin_reg;

    // The table never holds more entries than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PROCS))
        else $error("entry count exceeds capacity");

    // A held runner always points at a loaded, unfinished entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        runner_valid_reg |-> ((CNT_W'(runner_idx_reg) < count_reg)
                              && !done_reg[runner_idx_reg]))
        else $error("runner points at an invalid entry");

    // Every update produces exactly one result word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (result_valid && (tick_time == $past(time_reg))))
        else $error("update did not produce its result word");

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler: controller plus datapath.
// A load word is taken only while idle and busy stays low; it gives no result.
// A tick word first checks the held runner, then scans the entries one by one through the
// single comparator and store read port, and ends with an update of the chosen entry.
// The result word is strobed by result_valid for one cycle, right after the update cycle.
// Reset is asynchronous and active low; it empties the table and clears time and runner.
module preemptive_priority_scheduler
    import pps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [TIME_W-1:0]  arrival,
    input  logic [BURST_W-1:0] burst,
    input  logic [PRI_W-1:0]   priority_req,
    output logic               result_valid,
    output logic [TIME_W-1:0]  tick_time,
    output logic               idle,
    output logic [PID_W-1:0]   process_id,
    output logic               finished
);

    cmd_t    cmd;
    status_t status;

    pps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    pps_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .arrival      (arrival),
        .burst        (burst),
        .priority_req (priority_req),
        .status       (status),
        .result_valid (result_valid),
        .tick_time    (tick_time),
        .idle         (idle),
        .process_id   (process_id),
        .finished     (finished)
    );

endmodule
